// File: src/srfr_pkg.sv
// ----------------------------------------------------------------------------
// srfr_pkg
// Shared types, codes and byte tables of the serial reply frame recognizer.
// ----------------------------------------------------------------------------
package srfr_pkg;

    // event codes reported with every item
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_ACK_SEEN  = 3'd1;
    localparam logic [2:0] EV_FRAME_BYTE = 3'd2;
    localparam logic [2:0] EV_FRAME_DONE = 3'd3;
    localparam logic [2:0] EV_MISMATCH  = 3'd4;
    localparam logic [2:0] EV_STR_MATCH = 3'd5;

    // phase codes as reported on the result
    localparam logic [1:0] PHASE_ACK   = 2'd0;
    localparam logic [1:0] PHASE_FRAME = 2'd1;
    localparam logic [1:0] PHASE_HUNT  = 2'd2;

    // fixed sequence lengths and limits
    localparam int ACK_LEN   = 5;
    localparam int MATCH_LEN = 24;
    localparam int IDX_LIMIT = 64;

    localparam logic [7:0] FRAME_START = 8'hAB;

    // one result item
    typedef struct packed {
        logic [1:0] phase_now;
        logic [5:0] frame_index;
        logic [7:0] frame_byte;
        logic [2:0] ev_code;
    } result_t;

    // acknowledge bytes in order
    function automatic logic [7:0] ack_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'hAB;
            3'd1:    c = 8'h05;
            3'd2:    c = 8'h0A;
            3'd3:    c = 8'hDF;
            3'd4:    c = 8'h4E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // characters of the ready string "hop finished and standby"
    function automatic logic [7:0] ready_char(input logic [4:0] pos);
        logic [7:0] c;
        case (pos)
            5'd0:    c = "h";
            5'd1:    c = "o";
            5'd2:    c = "p";
            5'd3:    c = " ";
            5'd4:    c = "f";
            5'd5:    c = "i";
            5'd6:    c = "n";
            5'd7:    c = "i";
            5'd8:    c = "s";
            5'd9:    c = "h";
            5'd10:   c = "e";
            5'd11:   c = "d";
            5'd12:   c = " ";
            5'd13:   c = "a";
            5'd14:   c = "n";
            5'd15:   c = "d";
            5'd16:   c = " ";
            5'd17:   c = "s";
            5'd18:   c = "t";
            5'd19:   c = "a";
            5'd20:   c = "n";
            5'd21:   c = "d";
            5'd22:   c = "b";
            5'd23:   c = "y";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: src/srfr_core.sv
// ----------------------------------------------------------------------------
// srfr_core
// Recognizer state and the single-pass decision for one received byte.
// ----------------------------------------------------------------------------
module srfr_core #(
    parameter int PARAM_DEPTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic [7:0]         rx_byte,
    output srfr_pkg::result_t  result
);

    typedef enum logic [1:0] {
        ST_ACK   = 2'd0,
        ST_FRAME = 2'd1,
        ST_HUNT  = 2'd2,
        ST_IDLE  = 2'd3
    } phase_t;

    // frame bytes at or past this index overflow
    localparam int IDX_MAX = (PARAM_DEPTH < srfr_pkg::IDX_LIMIT) ?
                             PARAM_DEPTH : srfr_pkg::IDX_LIMIT;
    localparam logic [6:0] IDX_MAX_W = 7'(IDX_MAX);
    localparam logic [6:0] ACK_LEN_W = 7'(srfr_pkg::ACK_LEN);
    localparam logic [4:0] MATCH_LAST = 5'(srfr_pkg::MATCH_LEN - 1);

    phase_t      phase_reg, phase_next;
    logic [6:0]  fpos_reg, fpos_next;
    logic [7:0]  flen_reg, flen_next;
    logic [4:0]  spos_reg, spos_next;

    logic [6:0]  idx;
    logic        ack_hit;
    logic        str_hit;

    assign idx     = fpos_reg - ACK_LEN_W;
    assign ack_hit = (fpos_reg < ACK_LEN_W) &&
                     (rx_byte == srfr_pkg::ack_char(fpos_reg[2:0]));
    assign str_hit = (rx_byte == srfr_pkg::ready_char(spos_reg));

    // decision for the current byte
    always_comb begin
        phase_next         = phase_reg;
        fpos_next          = fpos_reg;
        flen_next          = flen_reg;
        spos_next          = spos_reg;
        result.ev_code     = srfr_pkg::EV_NONE;
        result.frame_byte  = 8'd0;
        result.frame_index = 6'd0;

        unique case (phase_reg) inside
            ST_ACK, ST_FRAME: begin
                if (fpos_reg < ACK_LEN_W) begin
                    // acknowledge match
                    if (ack_hit) begin
                        fpos_next = fpos_reg + 7'd1;
                        if (fpos_reg == ACK_LEN_W - 7'd1) begin
                            result.ev_code = srfr_pkg::EV_ACK_SEEN;
                            if (phase_reg == ST_ACK) begin
                                fpos_next  = 7'd0;
                                phase_next = ST_FRAME;
                            end
                        end
                    end else begin
                        fpos_next      = 7'd0;
                        result.ev_code = srfr_pkg::EV_MISMATCH;
                    end
                end else if (idx == 7'd0 && rx_byte != srfr_pkg::FRAME_START) begin
                    // bad frame start
                    fpos_next      = 7'd0;
                    result.ev_code = srfr_pkg::EV_MISMATCH;
                end else if (idx >= IDX_MAX_W) begin
                    // frame overflow
                    fpos_next      = 7'd0;
                    result.ev_code = srfr_pkg::EV_MISMATCH;
                end else begin
                    // capture a frame byte
                    if (idx == 7'd1) begin
                        flen_next = rx_byte;
                    end
                    fpos_next          = fpos_reg + 7'd1;
                    result.frame_byte  = rx_byte;
                    result.frame_index = idx[5:0];
                    result.ev_code     = srfr_pkg::EV_FRAME_BYTE;
                    if (idx >= 7'd2 && ({1'b0, idx} + 8'd1) == flen_reg) begin
                        result.ev_code = srfr_pkg::EV_FRAME_DONE;
                        phase_next     = ST_HUNT;
                    end
                end
            end
            ST_HUNT: begin
                // ready string hunt, no retry on a mismatch
                if (str_hit && spos_reg == MATCH_LAST) begin
                    spos_next      = 5'd0;
                    result.ev_code = srfr_pkg::EV_STR_MATCH;
                end else if (str_hit) begin
                    spos_next = spos_reg + 5'd1;
                end else begin
                    spos_next = 5'd0;
                end
            end
            default: begin
                result.ev_code = srfr_pkg::EV_NONE;
            end
        endcase

        result.phase_now = phase_next;
    end

    // state update when the item moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ST_ACK;
            fpos_reg  <= 7'd0;
            flen_reg  <= 8'd0;
            spos_reg  <= 5'd0;
        end else if (advance) begin
            phase_reg <= phase_next;
            fpos_reg  <= fpos_next;
            flen_reg  <= flen_next;
            spos_reg  <= spos_next;
        end
    end

endmodule

// File: src/serial_reply_frame_recognizer_unit.sv
// ----------------------------------------------------------------------------
// serial_reply_frame_recognizer_unit
// Recognizes acknowledge, reply frame and ready string in a serial byte stream.
// ----------------------------------------------------------------------------
// Every received byte gives exactly one result item. An item passes from input
// to output through the input register, then the result register, and one
// item can enter every cycle while the receiver does not stall the output: the
// only loop is the recognizer state, updated as the item passes from the input
// register to the result register. Result tdata carries the event code, the
// captured frame byte and its index, and the phase after the byte.
module serial_reply_frame_recognizer_unit #(
    parameter int PARAM_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // event_res[2:0], frame_byte[10:3],
                                   // frame_index[16:11], phase_now[18:17], zero
);

    logic              in_vld_reg, in_vld_next;
    logic [7:0]        in_byte_reg, in_byte_next;
    logic              out_vld_reg, out_vld_next;
    srfr_pkg::result_t out_res_reg, out_res_next;
    srfr_pkg::result_t core_res;
    logic              advance;

    // item moves from the input register into the result register
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    srfr_core #(
        .PARAM_DEPTH (PARAM_DEPTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .rx_byte (in_byte_reg),
        .result  (core_res)
    );

    // next values of the two pipeline registers
    always_comb begin
        in_vld_next  = in_vld_reg;
        in_byte_next = in_byte_reg;
        out_vld_next = out_vld_reg;
        out_res_next = out_res_reg;
        if (s_tvalid && s_tready) begin
            in_vld_next  = 1'b1;
            in_byte_next = s_tdata;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
        if (advance) begin
            out_vld_next = 1'b1;
            out_res_next = core_res;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
        in_byte_reg <= in_byte_next;
        out_res_reg <= out_res_next;
    end

    // result packing
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_res_reg.phase_now, out_res_reg.frame_index,
                       out_res_reg.frame_byte, out_res_reg.ev_code};

endmodule

// File: test/serial_reply_frame_recognizer_unit_tb.sv
// ----------------------------------------------------------------------------
// serial_reply_frame_recognizer_unit_tb
// Self-checking bench for the serial reply frame recognizer. Directed bytes
// hit the acknowledge and frame-start corner cases. Random traffic then runs
// in three parts: acknowledges with overflowing frames, one completed frame,
// and a long hunt for the ready string. A scoreboard class tracks the
// recognizer state, predicts one result item per accepted byte, compares each
// returned item against it. Both sides stall at random outside bytes 300-599.
// ----------------------------------------------------------------------------
module serial_reply_frame_recognizer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PARAM_DEPTH = 64;
    localparam int FRAME_LIMIT = (PARAM_DEPTH < srfr_pkg::IDX_LIMIT) ?
                                 PARAM_DEPTH : srfr_pkg::IDX_LIMIT;
    localparam logic [8*srfr_pkg::ACK_LEN-1:0]   ACK_SEQ    = 40'hAB_05_0A_DF_4E;
    localparam logic [8*srfr_pkg::MATCH_LEN-1:0] READY_TEXT = "hop finished and standby";
    localparam int RX_BYTES_TARGET = 1300;
    localparam int MATCH_TARGET    = 30;
    localparam int LIMIT_NS        = 2_000_000;
    localparam int REPORT_MAX      = 10;

    // acknowledge byte at a position
    function automatic logic [7:0] ack_at(input int pos);
        return ACK_SEQ[8*(srfr_pkg::ACK_LEN-1-pos) +: 8];
    endfunction

    // ready string character at a position
    function automatic logic [7:0] ready_at(input int pos);
        return READY_TEXT[8*(srfr_pkg::MATCH_LEN-1-pos) +: 8];
    endfunction

    // recognizer state tracking and result comparison
    class reply_scoreboard;
        logic [1:0]        phase;
        int                frame_pos;
        logic [7:0]        frame_len;
        int                str_pos;
        srfr_pkg::result_t awaited_reports[$];
        int                ev_count[6];
        int                checked;
        int                errors;

        function new();
            phase     = srfr_pkg::PHASE_ACK;
            frame_pos = 0;
            frame_len = '0;
            str_pos   = 0;
            checked   = 0;
            errors    = 0;
            foreach (ev_count[i]) ev_count[i] = 0;
        endfunction

        // one byte against the acknowledge sequence
        function logic [2:0] step_ack(input logic [7:0] ch);
            if (frame_pos < srfr_pkg::ACK_LEN && ch == ack_at(frame_pos)) begin
                frame_pos++;
                return (frame_pos == srfr_pkg::ACK_LEN) ? srfr_pkg::EV_ACK_SEEN
                                                        : srfr_pkg::EV_NONE;
            end
            frame_pos = 0;
            return srfr_pkg::EV_MISMATCH;
        endfunction

        // advance the state by one accepted byte and queue its result
        function void note_rx_byte(input logic [7:0] ch);
            srfr_pkg::result_t r;
            int                idx;
            r = '0;
            r.ev_code = srfr_pkg::EV_NONE;
            case (phase)
                srfr_pkg::PHASE_ACK: begin
                    r.ev_code = step_ack(ch);
                    if (r.ev_code == srfr_pkg::EV_ACK_SEEN) begin
                        frame_pos = 0;
                        phase     = srfr_pkg::PHASE_FRAME;
                    end
                end
                srfr_pkg::PHASE_FRAME: begin
                    if (frame_pos < srfr_pkg::ACK_LEN) begin
                        r.ev_code = step_ack(ch);
                    end else begin
                        idx = frame_pos - srfr_pkg::ACK_LEN;
                        if ((idx == 0 && ch != srfr_pkg::FRAME_START) ||
                            idx >= FRAME_LIMIT) begin
                            // bad frame start or overflow
                            frame_pos = 0;
                            r.ev_code = srfr_pkg::EV_MISMATCH;
                        end else begin
                            if (idx == 1) frame_len = ch;
                            frame_pos++;
                            r.frame_byte  = ch;
                            r.frame_index = 6'(idx);
                            r.ev_code     = srfr_pkg::EV_FRAME_BYTE;
                            // length only checked from index 2 on
                            if (idx >= 2 && idx + 1 == int'(frame_len)) begin
                                r.ev_code = srfr_pkg::EV_FRAME_DONE;
                                phase     = srfr_pkg::PHASE_HUNT;
                            end
                        end
                    end
                end
                srfr_pkg::PHASE_HUNT: begin
                    // no retry of the current byte on a mismatch
                    if (ch == ready_at(str_pos)) str_pos++;
                    else str_pos = 0;
                    if (str_pos == srfr_pkg::MATCH_LEN) begin
                        str_pos   = 0;
                        r.ev_code = srfr_pkg::EV_STR_MATCH;
                    end
                end
                default: ;
            endcase
            r.phase_now = phase;
            ev_count[r.ev_code]++;
            awaited_reports.push_back(r);
        endfunction

        // compare one returned item with the oldest prediction
        function void check_report(input logic [23:0] data);
            srfr_pkg::result_t got;
            srfr_pkg::result_t want;
            got = srfr_pkg::result_t'(data[18:0]);
            checked++;
            if (awaited_reports.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result item %h at %0t", data, $realtime);
                return;
            end
            want = awaited_reports.pop_front();
            if (got !== want || data[23:19] !== 5'd0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display({"result %0d: expected ev %0d byte %h idx %0d phase %0d, ",
                              "got ev %0d byte %h idx %0d phase %0d pad %b"},
                             checked, want.ev_code, want.frame_byte, want.frame_index,
                             want.phase_now, got.ev_code, got.frame_byte,
                             got.frame_index, got.phase_now, data[23:19]);
            end
        endfunction

        function int pending();
            return awaited_reports.size();
        endfunction

        // predictions never answered count as failures
        function void close_out();
            if (awaited_reports.size() != 0)
                $display("%0d result items never arrived", awaited_reports.size());
            errors += awaited_reports.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    reply_scoreboard sb;
    int sent   = 0;
    bit steady = 1'b0;

    serial_reply_frame_recognizer_unit #(
        .PARAM_DEPTH(PARAM_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // overall time limit
    initial begin
        #LIMIT_NS;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver stalls
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 25);
    end

    // result sampling
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_report(m_tdata);
    end

    // send one byte with an optional random gap before it
    task automatic send_byte(input logic [7:0] b);
        steady = (sent >= 300 && sent < 600);
        if (!steady && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < 25);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_rx_byte(b);
        sent++;
        @(negedge aclk);
    endtask

    task automatic send_ack();
        for (int i = 0; i < srfr_pkg::ACK_LEN; i++) send_byte(ack_at(i));
    endtask

    // bring the acknowledge match back to its start
    task automatic clear_ack_match();
        while (sb.phase != srfr_pkg::PHASE_HUNT && sb.frame_pos != 0) send_byte(8'h00);
    endtask

    // hold the sender until every predicted item has come back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    // stimulus
    initial begin
        int         kind;
        int         n;
        int         len;
        int         pick;
        logic [7:0] b;

        sb = new();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // acknowledge mismatches in phase 0, extremes of the byte
        send_byte(8'h00);
        send_byte(8'hFF);
        // a start byte that breaks a partial acknowledge is not retried
        send_byte(ack_at(0));
        send_byte(ack_at(1));
        send_byte(ack_at(0));
        // acknowledge moves to phase 1
        send_ack();
        // acknowledge in phase 1, then a bad frame start
        send_ack();
        send_byte(8'h00);
        // acknowledge mismatch inside phase 1
        for (int i = 0; i < srfr_pkg::ACK_LEN - 1; i++) send_byte(ack_at(i));
        send_byte(8'h00);

        // phase 1: overflowing frames, broken acknowledges, bad starts, noise
        while (sent < 470) begin
            kind = $urandom_range(0, 99);
            clear_ack_match();
            if (kind < 40) begin
                // short or oversize length, so the frame overflows
                send_ack();
                send_byte(srfr_pkg::FRAME_START);
                pick = $urandom_range(0, 3);
                len  = (pick < 3) ? pick : $urandom_range(FRAME_LIMIT + 1, 255);
                send_byte(8'(len));
                repeat (FRAME_LIMIT - 1) send_byte(8'($urandom));
            end else if (kind < 65) begin
                n = $urandom_range(1, srfr_pkg::ACK_LEN - 1);
                for (int i = 0; i < n; i++) send_byte(ack_at(i));
                b = 8'($urandom);
                if (b == ack_at(n)) b = ~b;
                send_byte(b);
            end else if (kind < 85) begin
                send_ack();
                b = 8'($urandom);
                if (b == srfr_pkg::FRAME_START) b = ~b;
                send_byte(b);
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end
        end

        hold_until_drained();

        // one frame that completes and moves to the string hunt
        while (sb.phase != srfr_pkg::PHASE_HUNT) begin
            clear_ack_match();
            send_ack();
            send_byte(srfr_pkg::FRAME_START);
            len = $urandom_range(3, FRAME_LIMIT);
            send_byte(8'(len));
            repeat (len - 2) send_byte(8'($urandom));
        end

        // phase 2: ready strings, corrupted and cut strings, noise
        while (sent < RX_BYTES_TARGET ||
               sb.ev_count[srfr_pkg::EV_STR_MATCH] < MATCH_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                // break any partial match so the full string lands
                if (sb.str_pos != 0) send_byte("#");
                for (int i = 0; i < srfr_pkg::MATCH_LEN; i++) send_byte(ready_at(i));
            end else if (kind < 75) begin
                pick = $urandom_range(0, srfr_pkg::MATCH_LEN - 1);
                for (int i = 0; i < srfr_pkg::MATCH_LEN; i++) begin
                    b = ready_at(i);
                    if (i == pick) b = b ^ (8'h01 << $urandom_range(0, 7));
                    send_byte(b);
                end
            end else if (kind < 90) begin
                n = $urandom_range(1, srfr_pkg::MATCH_LEN - 1);
                for (int i = 0; i < n; i++) send_byte(ready_at(i));
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
        end

        // drain and let the pipeline settle
        hold_until_drained();
        repeat (20) @(posedge aclk);
        sb.close_out();

        $display("sent %0d bytes: %0d acknowledges, %0d frame bytes, %0d frames done, %0d %s",
                 sent, sb.ev_count[srfr_pkg::EV_ACK_SEEN],
                 sb.ev_count[srfr_pkg::EV_FRAME_BYTE],
                 sb.ev_count[srfr_pkg::EV_FRAME_DONE], sb.ev_count[srfr_pkg::EV_MISMATCH],
                 "mismatches or overflows");
        $display("ready string found %0d times, %0d items checked, %0d errors",
                 sb.ev_count[srfr_pkg::EV_STR_MATCH], sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
src/srfr_pkg.sv
src/srfr_core.sv
src/serial_reply_frame_recognizer_unit.sv
test/serial_reply_frame_recognizer_unit_tb.sv
